FILE: rtl/tcce_pkg.sv
// Shared types, constants and helpers of the text console cursor engine.
// Used by tcce_screen_ram and text_console_cursor_engine_unit; depends on nothing.
package tcce_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Widths that follow from the geometry.
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;

    // Fixed field widths.
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOUR_W = 4;
    localparam int POS_W   = 11;
    localparam int INDEX_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

    typedef enum logic [1:0] {
        OP_PUT       = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOREGROUND = 2'd0,
        CFG_BACKGROUND = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } state_t;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        cell_pos = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

FILE: rtl/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: cursor, command sequencer and
// result register around the screen store. Depends on tcce_pkg and tcce_screen_ram.
//
// A character-cell console of COLUMNS x ROWS cells (80 x 25), each cell holding
// attribute << 8 | character, with the attribute background << 4 | foreground.
// Each request on the s_ side carries an operation in s_tuser (put character,
// backspace, clear, read cell) and yields exactly one result on the m_ side:
// the linear cursor position after the request, the cell contents for a read
// (zero otherwise, and zero for an index beyond the screen) and a flag that
// says whether the request scrolled the screen. A put that does not scroll and a
// backspace are done in ST_IDLE, so a run of them streams at one request per
// clock as long as results are taken; a read passes through ST_READ because of
// the store's registered read port. Clear sweeps the store with one write per
// cycle. A newline, or a put in the last column, on the last row scrolls: the
// store is copied up one row through its single read and write port, one cell
// per cycle with the bottom row blanked in the same sweep. After reset the
// store is cleared to zero by a sweep of every cell during which no request is
// accepted; configuration writes are taken at any time and only apply to cells
// written afterwards, so they should be made while the block is idle.
module text_console_cursor_engine_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [1:0]  s_tuser,    // [1:0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [10:0] cursor_position, [26:11] read_data,
                                    // [27] scrolled, rest zero

    input  logic                               cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcce_pkg::COLOUR_W-1:0]      cfg_data
);

    // Request fields.
    tcce_pkg::op_t                   in_op;
    logic [tcce_pkg::CHAR_W-1:0]     in_char;
    logic [tcce_pkg::INDEX_W-1:0]    in_index;

    assign in_op    = tcce_pkg::op_t'(s_tuser);
    assign in_char  = s_tdata[7:0];
    assign in_index = s_tdata[18:8];

    // Colour registers.
    logic [tcce_pkg::COLOUR_W-1:0] fg_reg;
    logic [tcce_pkg::COLOUR_W-1:0] bg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= 4'hF;
            bg_reg <= 4'h0;
        end
        else if (cfg_we)
        begin
            case (tcce_pkg::cfg_reg_t'(cfg_index))
                tcce_pkg::CFG_FOREGROUND: fg_reg <= cfg_data;
                tcce_pkg::CFG_BACKGROUND: bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [tcce_pkg::CELL_W-1:0] blank_cell;
    assign blank_cell = {bg_reg, fg_reg, tcce_pkg::BLANK_CODE};

    // Sequencer and cursor state.
    tcce_pkg::state_t               state_reg, state_next;
    logic [tcce_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [tcce_pkg::COL_W-1:0]     col_reg, col_next;
    logic [tcce_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           oob_reg, oob_next;

    // Result register.
    logic                           m_valid_reg;
    logic [tcce_pkg::POS_W-1:0]     m_pos_reg;
    logic [tcce_pkg::CELL_W-1:0]    m_rdata_reg;
    logic                           m_scr_reg;

    logic                           out_load;
    logic [tcce_pkg::POS_W-1:0]     out_pos;
    logic [tcce_pkg::CELL_W-1:0]    out_rdata;
    logic                           out_scr;

    // Store port.
    logic                           mem_we;
    logic [tcce_pkg::ADDR_W-1:0]    mem_waddr;
    logic [tcce_pkg::CELL_W-1:0]    mem_wdata;
    logic                           mem_re;
    logic [tcce_pkg::ADDR_W-1:0]    mem_raddr;
    logic [tcce_pkg::CELL_W-1:0]    mem_rdata;

    tcce_screen_ram u_screen
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Decode of the current request against the cursor.
    logic                           accept;
    logic                           at_last_row;
    logic                           at_last_col;
    logic                           at_origin;
    logic                           is_newline;
    logic                           need_scroll;
    logic [tcce_pkg::ADDR_W-1:0]    cur_pos;

    assign s_tready    = (state_reg == tcce_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept      = s_tvalid && s_tready;
    assign at_last_row = (row_reg == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1));
    assign at_last_col = (col_reg == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1));
    assign at_origin   = (row_reg == '0) && (col_reg == '0);
    assign is_newline  = (in_char == tcce_pkg::NEWLINE_CODE);
    assign need_scroll = (in_op == tcce_pkg::OP_PUT) && (is_newline || at_last_col) && at_last_row;
    assign cur_pos     = tcce_pkg::cell_pos(row_reg, col_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcce_pkg::ST_INIT:
            begin
                if (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1))
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        tcce_pkg::OP_PUT:
                            state_next = need_scroll ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_IDLE;
                        tcce_pkg::OP_CLEAR:     state_next = tcce_pkg::ST_CLEAR;
                        tcce_pkg::OP_READ:      state_next = tcce_pkg::ST_READ;
                        default:                state_next = tcce_pkg::ST_IDLE;
                    endcase
                end
            end
            tcce_pkg::ST_READ:
            begin
                state_next = tcce_pkg::ST_IDLE;
            end
            tcce_pkg::ST_SCROLL:
            begin
                if (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::CELLS))
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_CLEAR:
            begin
                if (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1))
                begin
                    state_next = tcce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcce_pkg::ST_INIT;
            end
        endcase
    end

    // Datapath, store accesses and result loading.
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        cnt_next  = cnt_reg;
        oob_next  = oob_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        out_load  = 1'b0;
        out_rdata = '0;
        out_scr   = 1'b0;

        case (state_reg)
            tcce_pkg::ST_INIT:
            begin
                // Power-up clearing pass: the store starts all zero.
                mem_we    = 1'b1;
                mem_waddr = tcce_pkg::ADDR_W'(cnt_reg);
                cnt_next  = cnt_reg + 1'b1;
            end
            tcce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    case (in_op)
                        tcce_pkg::OP_PUT:
                        begin
                            if (!is_newline)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_pos;
                                mem_wdata = {bg_reg, fg_reg, in_char};
                            end
                            if (is_newline || at_last_col)
                            begin
                                col_next = '0;
                                if (!at_last_row)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                            // A scrolling put reports once the sweep is done.
                            out_load = !need_scroll;
                        end
                        tcce_pkg::OP_BACKSPACE:
                        begin
                            if (!at_origin)
                            begin
                                if (col_reg == '0)
                                begin
                                    row_next = row_reg - 1'b1;
                                    col_next = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                mem_we    = 1'b1;
                                mem_waddr = cur_pos - 1'b1;
                                mem_wdata = blank_cell;
                            end
                            out_load = 1'b1;
                        end
                        tcce_pkg::OP_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        tcce_pkg::OP_READ:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = tcce_pkg::ADDR_W'(in_index);
                            oob_next  = !(32'(in_index) < 32'(tcce_pkg::CELLS));
                        end
                        default: ;
                    endcase
                end
            end
            tcce_pkg::ST_READ:
            begin
                out_load  = 1'b1;
                out_rdata = oob_reg ? '0 : mem_rdata;
            end
            tcce_pkg::ST_SCROLL:
            begin
                // Cell n+COLUMNS is read at count n and written to cell n in the
                // cycle after; the bottom row is blanked in the same pass.
                if (cnt_reg < tcce_pkg::CNT_W'(tcce_pkg::CELLS - tcce_pkg::COLUMNS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = tcce_pkg::ADDR_W'(cnt_reg + tcce_pkg::CNT_W'(tcce_pkg::COLUMNS));
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tcce_pkg::ADDR_W'(cnt_reg - 1'b1);
                    mem_wdata = (cnt_reg <= tcce_pkg::CNT_W'(tcce_pkg::CELLS - tcce_pkg::COLUMNS))
                                ? mem_rdata : blank_cell;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::CELLS))
                begin
                    out_load = 1'b1;
                    out_scr  = 1'b1;
                end
            end
            tcce_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = tcce_pkg::ADDR_W'(cnt_reg);
                mem_wdata = blank_cell;
                cnt_next  = cnt_reg + 1'b1;
                out_load  = (cnt_reg == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1));
            end
            default: ;
        endcase

        out_pos = tcce_pkg::POS_W'(tcce_pkg::cell_pos(row_next, col_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tcce_pkg::ST_INIT;
            row_reg     <= '0;
            col_reg     <= '0;
            cnt_reg     <= '0;
            oob_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            oob_reg   <= oob_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_pos_reg   <= out_pos;
            m_rdata_reg <= out_rdata;
            m_scr_reg   <= out_scr;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_scr_reg, m_rdata_reg, m_pos_reg};

`ifndef SYNTHESIS
    // The cursor never leaves the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)
         || row_reg == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1))
        && (col_reg < tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1)
         || col_reg == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1)))
        else $error("cursor outside the screen");

    // A new result is never loaded over one that is still waiting.
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("result register overrun");

    // A scrolling request always leaves the cursor at the start of the last row.
    a_scroll_position: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_scr_reg)
        |-> m_pos_reg == tcce_pkg::POS_W'((tcce_pkg::ROWS - 1) * tcce_pkg::COLUMNS))
        else $error("scroll result with wrong cursor position");

    // Only a read reports cell contents.
    a_rdata_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg != tcce_pkg::ST_READ) |-> out_rdata == '0)
        else $error("cell data reported for a non-read request");
`endif

endmodule

FILE: rtl/tcce_screen_ram.sv
// Screen store of the text console: one write port and one read port,
// read data registered. Depends on tcce_pkg for its size.
module tcce_screen_ram
(
    input  logic                                clk,
    input  logic                                we,
    input  logic [tcce_pkg::ADDR_W-1:0]         waddr,
    input  logic [tcce_pkg::CELL_W-1:0]         wdata,
    input  logic                                re,
    input  logic [tcce_pkg::ADDR_W-1:0]         raddr,
    output logic [tcce_pkg::CELL_W-1:0]         rdata
);

    logic [tcce_pkg::CELL_W-1:0] cells_mem [tcce_pkg::CELLS];
    logic [tcce_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cells_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= cells_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
